[rtl/b2da_pkg.sv]
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by every module of the block and by its checker.
package b2da_pkg;

  localparam int VALUE_W        = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int DIGITS         = 10;
  localparam int DIGIT_IDX_W    = $clog2(DIGITS);
  localparam int CHAR_W         = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  // BCD accumulator plus the binary bits still to be shifted in, MSB at the top
  typedef struct packed {
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
  } cell_data_t;

endpackage

[rtl/binary_to_decimal_ascii_unit.sv]
// Binary to decimal ASCII converter, top level.
// Depends on b2da_pkg, b2da_cell and b2da_serializer.
//
// Usage:
//   Input channel: value / value_valid / value_stall. The low VALUE_BITS bits
//   of value are converted; higher bits are ignored.
//   Output channel: digit_char / last / digit_valid / digit_stall. One beat per
//   decimal digit, most significant first, no leading zeros ('0' for zero);
//   last marks the final digit of a number.
//   Path: each number passes through the chain of cells, then the serializer
//   register, before its first digit is shown, when the output is free.
//   Throughput: a number with n digits (1 to 10) takes n digit beats of the
//   output; that single digit port sets the sustained rate. The chain of
//   VALUE_BITS cells holds up to VALUE_BITS numbers in flight and moves as one.
//   Stall: while the receiver stalls, the current digit holds; once the chain
//   end is full and waiting, value_stall rises.
//   Reset (rst, synchronous): empties the chain and the output; nothing emitted.
module binary_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [b2da_pkg::VALUE_W-1:0]  value,
  input  logic                          value_valid,
  output logic                          value_stall,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
  output logic                          last,
  output logic                          digit_valid,
  input  logic                          digit_stall
);
  import b2da_pkg::*;

  localparam int ALIGN = VALUE_W - VALUE_BITS;

  logic       en;
  logic       take;
  cell_data_t head;
  logic       cell_valid [VALUE_BITS];
  cell_data_t cell_data  [VALUE_BITS];

  // bits above VALUE_BITS fall off the top of the aligned word
  assign head = '{bcd: '0, bin: VALUE_W'(value << ALIGN)};

  assign en          = !cell_valid[VALUE_BITS-1] || take;
  assign value_stall = !en;

  for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      b2da_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .valid_in (value_valid),
        .data_in  (head),
        .valid    (cell_valid[i]),
        .data     (cell_data[i])
      );
    end else begin : g_next
      b2da_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .valid_in (cell_valid[i-1]),
        .data_in  (cell_data[i-1]),
        .valid    (cell_valid[i]),
        .data     (cell_data[i])
      );
    end
  end

  b2da_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (cell_valid[VALUE_BITS-1]),
    .load_data   (cell_data[VALUE_BITS-1].bcd),
    .take        (take),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit_char  (digit_char),
    .last        (last)
  );

endmodule

[rtl/b2da_cell.sv]
// One double-dabble step: add-3 on every BCD digit of 5 or more, then shift in one bit.
// Depends on b2da_pkg.
module b2da_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   valid_in,
  input  b2da_pkg::cell_data_t   data_in,
  output logic                   valid,
  output b2da_pkg::cell_data_t   data
);
  import b2da_pkg::*;

  bcd_t       adj;
  cell_data_t data_next;

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (data_in.bcd[k] >= 4'd5) begin
        adj[k] = data_in.bcd[k] + 4'd3;
      end else begin
        adj[k] = data_in.bcd[k];
      end
    end
    // top bit of the top digit never carries for a 32-bit value
    data_next.bcd = {adj[DIGITS-1][2:0], adj[DIGITS-2:0], data_in.bin[VALUE_W-1]};
    data_next.bin = {data_in.bin[VALUE_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

[rtl/b2da_serializer.sv]
// Takes a finished BCD word from the end of the cell chain and sends its digits
// as ASCII, most significant first, leading zeros dropped. Depends on b2da_pkg.
module b2da_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load_valid,
  input  b2da_pkg::bcd_t                load_data,
  output logic                          take,
  output logic                          digit_valid,
  input  logic                          digit_stall,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
  output logic                          last
);
  import b2da_pkg::*;

  logic                   busy;
  bcd_t                   bcd;
  logic [DIGIT_IDX_W-1:0] idx;
  logic [DIGIT_IDX_W-1:0] top;
  logic                   beat_done;

  // highest non-zero digit; zero value still gives one digit
  always_comb begin
    top = '0;
    for (int k = 1; k < DIGITS; k++) begin
      if (load_data[k] != 4'd0) begin
        top = DIGIT_IDX_W'(k);
      end
    end
  end

  assign beat_done = busy && !digit_stall;
  // a new word comes in on the same edge the final digit leaves
  assign take      = !busy || (beat_done && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bcd <= load_data;
      idx <= top;
    end else if (beat_done) begin
      idx <= idx - 1'b1;
    end
  end

  assign digit_valid = busy;
  assign digit_char  = ASCII_ZERO + {2'b00, bcd[idx]};
  assign last        = (idx == '0);

endmodule

[rtl/b2da_checker.sv]
// Port-level checks for binary_to_decimal_ascii_unit, bound to the top level.
// Depends on b2da_pkg.
module b2da_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          digit_valid,
  input logic                          digit_stall,
  input logic [b2da_pkg::CHAR_W-1:0]   digit_char,
  input logic                          last
);
  import b2da_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !digit_valid)
    else $error("digit beat shown straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    digit_valid && digit_stall |=> digit_valid && $stable(digit_char) && $stable(last))
    else $error("stalled digit beat changed");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_NINE))
    else $error("digit_char is not a decimal digit");

  // a number that follows straight after the last digit of the one before and opens with '0' must be zero itself
  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    $past(digit_valid && !digit_stall && last) && digit_valid && digit_char == ASCII_ZERO
    |-> last)
    else $error("leading zero emitted");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (
  .clk         (clk),
  .rst         (rst),
  .digit_valid (digit_valid),
  .digit_stall (digit_stall),
  .digit_char  (digit_char),
  .last        (last)
);

[tb/tb_binary_to_decimal_ascii_unit.sv]
// Self-checking testbench for binary_to_decimal_ascii_unit: directed table then random values.
// Each accepted value's digit beats come from the predictor or table text; each is checked.
// Depends on b2da_pkg and the converter RTL.
module tb_binary_to_decimal_ascii_unit;
  import b2da_pkg::*;

  localparam int VALUE_BITS   = VALUE_BITS_DEF;
  localparam int LATENCY      = VALUE_BITS + 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int N_PER_PHASE  = 50;
  localparam int N_DIR        = 18;
  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } digit_beat_t;

  // an empty text means the row is checked against the predictor
  typedef struct {
    logic [VALUE_W-1:0] v;
    string              text;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    '{32'd0,          "0"},
    '{32'hFFFF_FFFF,  "4294967295"},
    '{32'd1000000000, "1000000000"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{32'd1,          ""},
    '{32'd99,         ""},
    '{32'd100,        ""},
    '{32'd999999999,  ""},
    '{32'd4000000000, ""},
    '{32'h8000_0000,  ""},
    '{32'h5555_5555,  ""},
    '{32'hAAAA_AAAA,  ""},
    '{32'd12345,      ""},
    '{32'd10000,      ""},
    '{32'hFFFF_FFFE,  ""},
    '{32'd0,          ""},
    '{32'h0000_0001,  ""}
  };

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic [VALUE_W-1:0]  value       = '0;
  logic                value_valid = 1'b0;
  logic                value_stall;
  logic [CHAR_W-1:0]   digit_char;
  logic                last;
  logic                digit_valid;
  logic                digit_stall = 1'b0;

  digit_beat_t digits_pending [$];
  digit_beat_t want;
  int          errors      = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  binary_to_decimal_ascii_unit #(.VALUE_BITS(VALUE_BITS)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .digit_char  (digit_char),
    .last        (last),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    digit_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && digit_valid && !digit_stall) begin
      if (digits_pending.size() == 0) begin
        $error("digit beat with nothing expected: digit_char=%0d last=%0b", digit_char, last);
        errors++;
      end else begin
        want = digits_pending.pop_front();
        if (digit_char !== want.ch) begin
          $error("digit_char: expected %0d, got %0d", want.ch, digit_char);
          errors++;
        end
        if (last !== want.is_last) begin
          $error("last: expected %0b, got %0b", want.is_last, last);
          errors++;
        end
      end
    end
  end

  // decimal digits of the masked value, most significant first
  task automatic push_decimal(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] rem;
    logic [3:0]         rev [DIGITS];
    int                 n;
    digit_beat_t        beat;
    rem = raw & VALUE_MASK;
    n = 0;
    do begin
      rev[n] = 4'(rem % 10);
      rem = rem / 10;
      n++;
    end while (rem != 0 && n < DIGITS);
    for (int k = 0; k < n; k++) begin
      beat.ch      = ASCII_ZERO + CHAR_W'(rev[n-1-k]);
      beat.is_last = (k == n - 1);
      digits_pending.push_back(beat);
    end
  endtask

  task automatic push_text(input string s);
    byte         c;
    digit_beat_t beat;
    for (int i = 0; i < s.len(); i++) begin
      c            = s[i];
      beat.ch      = c[CHAR_W-1:0];
      beat.is_last = (i == s.len() - 1);
      digits_pending.push_back(beat);
    end
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
    while ($urandom_range(99) < send_idle_pct) begin
      value_valid <= 1'b0;
      @(posedge clk);
    end
    value       <= v;
    value_valid <= 1'b1;
    do @(posedge clk); while (!(value_valid && !value_stall));
    if (text.len() == 0) push_decimal(v);
    else push_text(text);
  endtask

  // hold the input low until every predicted beat has come out
  task automatic drain_output();
    value_valid <= 1'b0;
    while (digits_pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] p;
    p = 1;
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(99);
      2: return $urandom >> $urandom_range(31);
      3: begin
        repeat ($urandom_range(9)) p = p * 10;
        return p - $urandom_range(1);
      end
      default: return 32'hFFFF_FFFF - $urandom_range(1000);
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 59;
    for (int i = 0; i < N_DIR; i++) send_value(dir_rows[i].v, dir_rows[i].text);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 28; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < N_PER_PHASE; i++) begin
        if (ph == 0 && i == N_PER_PHASE / 2) drain_output();
        else send_value(random_value(), "");
      end
      drain_output();
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (digits_pending.size() != 0) begin
      $error("%0d digit beats never arrived", digits_pending.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/b2da_pkg.sv
rtl/b2da_cell.sv
rtl/b2da_serializer.sv
rtl/binary_to_decimal_ascii_unit.sv
rtl/b2da_checker.sv
tb/tb_binary_to_decimal_ascii_unit.sv
